/* rtl/core/bht_pkg.sv */
// Shared types and codes for the bitmap handle table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bht_pkg;

    localparam int unsigned WORD_BITS = 32;

    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_GET   = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_TEST  = 3'd3;
    localparam logic [2:0] CMD_FREE  = 3'd4;
    localparam logic [2:0] CMD_FDOM  = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOT_OCC = 2'd2;

    localparam logic [1:0] TYPE_WEAK   = 2'd0;
    localparam logic [1:0] TYPE_NORMAL = 2'd2;
    localparam logic [1:0] TYPE_PINNED = 2'd3;

    localparam logic [31:0] FULL_WORD      = 32'hffff_ffff;
    localparam logic [63:0] COLLECTED_MARK = 64'hffff_ffff_ffff_ffff;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_ACCESS,
        S_FDOM
    } t_state;

    typedef struct packed {
        logic obj;
        logic dom;
    } t_data_we;

    function automatic logic [4:0] lowest_zero(input logic [31:0] w);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!w[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bht_occ_mem.sv */
// Occupancy bitmap memory, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bht_occ_mem #(
    parameter int AW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);
    logic [31:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/bht_data_mem.sv */
// Object reference and domain id stores, shared addressing.
// Depends on bht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bht_data_mem #(
    parameter int AW = 12
) (
    input  wire logic             i_clk,
    input  wire bht_pkg::t_data_we i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [63:0]      i_obj_wdata,
    input  wire logic [15:0]      i_dom_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [63:0]      o_obj_rdata,
    output logic      [15:0]      o_dom_rdata
);
    logic [63:0] obj_mem [2**AW];
    logic [15:0] dom_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we.obj) begin
            obj_mem[i_waddr] <= i_obj_wdata;
        end
        if (i_we.dom) begin
            dom_mem[i_waddr] <= i_dom_wdata;
        end
        o_obj_rdata <= obj_mem[i_raddr];
        o_dom_rdata <= dom_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/bht_ctrl.sv */
// Command sequencer: hints, sizes, bitmap scan and read-modify-write.
// Depends on bht_pkg; drives bht_occ_mem and bht_data_mem.
`timescale 1ns / 1ps
`default_nettype none
module bht_ctrl #(
    parameter int MAX_SLOTS     = 1024,
    parameter int INITIAL_SLOTS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [1:0]  i_handle_type,
    input  wire logic [9:0]  i_handle_slot,
    input  wire logic [63:0] i_object_ref,
    input  wire logic [15:0] i_domain_id,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [1:0]       o_out_type,
    output logic [9:0]       o_out_slot,
    output logic [63:0]      o_target_ref,
    output logic             o_in_domain,
    output logic             o_occ_we,
    output logic [1+$clog2(MAX_SLOTS/32):0] o_occ_waddr,
    output logic [31:0]      o_occ_wdata,
    output logic [1+$clog2(MAX_SLOTS/32):0] o_occ_raddr,
    input  wire logic [31:0] i_occ_rdata,
    output bht_pkg::t_data_we o_d_we,
    output logic [1+$clog2(MAX_SLOTS):0] o_d_waddr,
    output logic [63:0]      o_obj_wdata,
    output logic [15:0]      o_dom_wdata,
    output logic [1+$clog2(MAX_SLOTS):0] o_d_raddr,
    input  wire logic [63:0] i_obj_rdata,
    input  wire logic [15:0] i_dom_rdata
);
    localparam int WPT    = MAX_SLOTS / 32;
    localparam int WIDX   = $clog2(WPT);
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int SZ_W   = SLOT_W + 1;
    localparam int OCC_AW = WIDX + 2;
    localparam int CMP_W  = (SZ_W > 10) ? SZ_W : 10;
    localparam logic [SZ_W-1:0] HALF_MAX = SZ_W'(MAX_SLOTS / 2);
    localparam logic [SZ_W-1:0] MAX_SZ   = SZ_W'(MAX_SLOTS);
    localparam logic [SZ_W-1:0] INIT_SZ  = SZ_W'(INITIAL_SLOTS);

    bht_pkg::t_state r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [1:0]        r_t, n_t;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [63:0]       r_obj, n_obj;
    logic [15:0]       r_dom, n_dom;
    logic [WIDX-1:0]   r_w, n_w;
    logic [SLOT_W-1:0] r_k, n_k;
    logic [1:0]        r_tt, n_tt;
    logic [OCC_AW-1:0] r_cnt, n_cnt;
    logic [WIDX-1:0]   r_hint [4];
    logic [WIDX-1:0]   n_hint [4];
    logic [SZ_W-1:0]   r_size [4];
    logic [SZ_W-1:0]   n_size [4];
    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic [1:0]        r_otype, n_otype;
    logic [9:0]        r_oslot, n_oslot;
    logic [63:0]       r_tref, n_tref;
    logic              r_indom, n_indom;
    logic              r_fwd_we;
    logic [OCC_AW-1:0] r_fwd_waddr, r_fwd_raddr;
    logic [31:0]       r_fwd_wdata;

    logic [31:0]       w_word;
    logic [4:0]        w_lz;
    logic [WIDX:0]     w_nw;
    logic [WIDX:0]     w_winc;
    logic [WIDX-1:0]   w_wnx;
    logic [SZ_W-1:0]   w_kinc;
    logic              w_klast;
    logic              w_clr;
    logic              w_sok;
    logic [SLOT_W-1:0] w_sidx;
    logic [SLOT_W-1:0] w_aslot;

    // bypass a same-word write that raced the read
    assign w_word = (r_fwd_we && r_fwd_waddr == r_fwd_raddr) ? r_fwd_wdata : i_occ_rdata;
    assign w_lz   = bht_pkg::lowest_zero(w_word);
    assign w_nw   = r_size[r_t][SZ_W-1:5];
    assign w_winc = {1'b0, r_w} + (WIDX+1)'(1);
    assign w_wnx  = (w_winc == w_nw) ? '0 : w_winc[WIDX-1:0];
    assign w_kinc = {1'b0, r_k} + SZ_W'(1);
    assign w_klast = (w_kinc == r_size[r_tt]);
    assign w_clr  = w_word[r_k[4:0]] && (i_dom_rdata == r_dom)
                    && !(r_tt >= bht_pkg::TYPE_NORMAL && i_obj_rdata == '0);
    assign w_sidx = SLOT_W'(i_handle_slot);
    assign w_sok  = CMP_W'(i_handle_slot) < CMP_W'(r_size[i_handle_type]);
    assign w_aslot = {r_w, w_lz};

    always_comb begin
        n_state = r_state;
        case (r_state)
            bht_pkg::S_CLEAR: begin
                if (r_cnt == OCC_AW'(4 * WPT - 1)) begin
                    n_state = bht_pkg::S_IDLE;
                end
            end
            bht_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        bht_pkg::CMD_ALLOC: n_state = bht_pkg::S_ALLOC;
                        bht_pkg::CMD_GET, bht_pkg::CMD_SET,
                        bht_pkg::CMD_TEST, bht_pkg::CMD_FREE: begin
                            if (w_sok) begin
                                n_state = bht_pkg::S_ACCESS;
                            end
                        end
                        bht_pkg::CMD_FDOM: n_state = bht_pkg::S_FDOM;
                        default: n_state = bht_pkg::S_IDLE;
                    endcase
                end
            end
            bht_pkg::S_ALLOC: begin
                if (w_word != bht_pkg::FULL_WORD || w_wnx == r_hint[r_t]) begin
                    n_state = bht_pkg::S_IDLE;
                end
            end
            bht_pkg::S_ACCESS: n_state = bht_pkg::S_IDLE;
            bht_pkg::S_FDOM: begin
                if (w_klast && r_tt == bht_pkg::TYPE_NORMAL) begin
                    n_state = bht_pkg::S_IDLE;
                end
            end
            default: n_state = bht_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd; n_t = r_t; n_slot = r_slot; n_obj = r_obj; n_dom = r_dom;
        n_w = r_w; n_k = r_k; n_tt = r_tt; n_cnt = r_cnt;
        n_hint = r_hint; n_size = r_size;
        n_valid = 1'b0; n_status = r_status; n_otype = r_otype; n_oslot = r_oslot;
        n_tref = r_tref; n_indom = r_indom;
        o_occ_we = 1'b0; o_occ_waddr = '0; o_occ_wdata = '0; o_occ_raddr = '0;
        o_d_we = '0; o_d_waddr = '0; o_obj_wdata = r_obj; o_dom_wdata = r_dom;
        o_d_raddr = '0;
        case (r_state)
            bht_pkg::S_CLEAR: begin
                o_occ_we    = 1'b1;
                o_occ_waddr = r_cnt;
                n_cnt       = r_cnt + OCC_AW'(1);
            end
            bht_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_command; n_t = i_handle_type; n_slot = w_sidx;
                    n_obj = i_object_ref; n_dom = i_domain_id;
                    n_status = bht_pkg::ST_DONE; n_otype = '0; n_oslot = '0;
                    n_tref = '0; n_indom = 1'b0;
                    case (i_command)
                        bht_pkg::CMD_ALLOC: begin
                            n_w = r_hint[i_handle_type];
                            o_occ_raddr = {i_handle_type, r_hint[i_handle_type]};
                        end
                        bht_pkg::CMD_GET, bht_pkg::CMD_SET,
                        bht_pkg::CMD_TEST, bht_pkg::CMD_FREE: begin
                            o_occ_raddr = {i_handle_type, w_sidx[SLOT_W-1:5]};
                            o_d_raddr   = {i_handle_type, w_sidx};
                            if (!w_sok) begin
                                n_valid  = 1'b1;
                                n_status = bht_pkg::ST_NOT_OCC;
                            end
                        end
                        bht_pkg::CMD_FDOM: begin
                            n_tt = bht_pkg::TYPE_WEAK;
                            n_k  = '0;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            bht_pkg::S_ALLOC: begin
                o_d_waddr = {r_t, w_aslot};
                o_occ_waddr = {r_t, r_w};
                if (w_word != bht_pkg::FULL_WORD) begin
                    o_occ_we    = 1'b1;
                    o_occ_wdata = w_word | (32'h1 << w_lz);
                    o_d_we      = '{obj: 1'b1, dom: 1'b1};
                    n_hint[r_t] = r_w;
                    n_valid = 1'b1; n_otype = r_t; n_oslot = 10'(w_aslot);
                end else if (w_wnx == r_hint[r_t]) begin
                    n_valid = 1'b1;
                    if (r_size[r_t] > HALF_MAX) begin
                        n_status = bht_pkg::ST_FULL;
                    end else begin
                        o_occ_we    = 1'b1;
                        o_occ_waddr = {r_t, w_nw[WIDX-1:0]};
                        o_occ_wdata = 32'h1;
                        o_d_we      = '{obj: 1'b1, dom: 1'b1};
                        o_d_waddr   = {r_t, w_nw[WIDX-1:0], 5'd0};
                        n_hint[r_t] = w_nw[WIDX-1:0];
                        n_size[r_t] = {r_size[r_t][SZ_W-2:0], 1'b0};
                        n_otype = r_t;
                        n_oslot = 10'({w_nw[WIDX-1:0], 5'd0});
                    end
                end else begin
                    n_w = w_wnx;
                    o_occ_raddr = {r_t, w_wnx};
                end
            end
            bht_pkg::S_ACCESS: begin
                n_valid = 1'b1;
                o_occ_waddr = {r_t, r_slot[SLOT_W-1:5]};
                o_d_waddr   = {r_t, r_slot};
                if (!w_word[r_slot[4:0]]) begin
                    n_status = bht_pkg::ST_NOT_OCC;
                end else begin
                    case (r_cmd)
                        bht_pkg::CMD_GET: begin
                            if (r_t < bht_pkg::TYPE_NORMAL
                                && i_obj_rdata == bht_pkg::COLLECTED_MARK) begin
                                n_tref = '0;
                            end else begin
                                n_tref = i_obj_rdata;
                            end
                        end
                        bht_pkg::CMD_SET: o_d_we = '{obj: 1'b1, dom: 1'b1};
                        bht_pkg::CMD_TEST: begin
                            n_indom = (r_t >= bht_pkg::TYPE_NORMAL && i_obj_rdata == '0)
                                      || (i_dom_rdata == r_dom);
                        end
                        bht_pkg::CMD_FREE: begin
                            o_occ_we    = 1'b1;
                            o_occ_wdata = w_word & ~(32'h1 << r_slot[4:0]);
                            o_d_we      = '{obj: 1'b1, dom: 1'b0};
                            o_obj_wdata = '0;
                        end
                        default: n_status = bht_pkg::ST_DONE;
                    endcase
                end
            end
            bht_pkg::S_FDOM: begin
                o_occ_waddr = {r_tt, r_k[SLOT_W-1:5]};
                o_d_waddr   = {r_tt, r_k};
                if (w_clr) begin
                    o_occ_we    = 1'b1;
                    o_occ_wdata = w_word & ~(32'h1 << r_k[4:0]);
                    o_d_we      = '{obj: 1'b1, dom: 1'b0};
                    o_obj_wdata = '0;
                end
                if (w_klast) begin
                    if (r_tt == bht_pkg::TYPE_NORMAL) begin
                        n_valid = 1'b1;
                    end else begin
                        n_tt = r_tt + 2'd1;
                        n_k  = '0;
                        o_occ_raddr = {r_tt + 2'd1, {WIDX{1'b0}}};
                        o_d_raddr   = {r_tt + 2'd1, {SLOT_W{1'b0}}};
                    end
                end else begin
                    n_k = w_kinc[SLOT_W-1:0];
                    o_occ_raddr = {r_tt, w_kinc[SLOT_W-1:5]};
                    o_d_raddr   = {r_tt, w_kinc[SLOT_W-1:0]};
                end
            end
            default: n_valid = 1'b0;
        endcase
        if (r_state == bht_pkg::S_IDLE && i_start && i_command == bht_pkg::CMD_FDOM) begin
            o_occ_raddr = '0;
            o_d_raddr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bht_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_valid  <= 1'b0;
            r_fwd_we <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_hint[i] <= '0;
                r_size[i] <= INIT_SZ;
            end
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_valid  <= n_valid;
            r_fwd_we <= o_occ_we;
            r_hint   <= n_hint;
            r_size   <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_t <= n_t; r_slot <= n_slot; r_obj <= n_obj; r_dom <= n_dom;
        r_w <= n_w; r_k <= n_k; r_tt <= n_tt;
        r_status <= n_status; r_otype <= n_otype; r_oslot <= n_oslot;
        r_tref <= n_tref; r_indom <= n_indom;
        r_fwd_waddr <= o_occ_waddr;
        r_fwd_wdata <= o_occ_wdata;
        r_fwd_raddr <= o_occ_raddr;
    end

    assign o_busy       = (r_state != bht_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_out_type   = r_otype;
    assign o_out_slot   = r_oslot;
    assign o_target_ref = r_tref;
    assign o_in_domain  = r_indom;

`ifndef SYNTHESIS
    a_clear_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bht_pkg::S_CLEAR |-> !o_d_we.obj && !o_d_we.dom)
        else $error("data store written during bitmap clear");
    a_hint_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bht_pkg::S_ALLOC |-> {1'b0, r_hint[r_t]} < w_nw)
        else $error("word hint beyond table size");
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bht_pkg::S_ALLOC |-> r_size[r_t] <= MAX_SZ && r_size[r_t] >= INIT_SZ)
        else $error("table size out of bounds");
    a_full_from_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bht_pkg::ST_FULL |-> $past(r_state) == bht_pkg::S_ALLOC)
        else $error("full status outside allocate");
    a_fdom_no_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bht_pkg::S_FDOM |-> r_tt != bht_pkg::TYPE_PINNED)
        else $error("free-domain walked the pinned table");
`endif
endmodule
`default_nettype wire

/* rtl/core/bitmap_handle_table_top.sv */
// Bitmap handle table top level: sequencer plus bitmap and data memories.
// Depends on bht_pkg, bht_ctrl, bht_occ_mem, bht_data_mem.
//
// Usage:
//   Command channel: a transfer happens on a clock edge with start high and
//   busy low; command, handle type, slot, object reference and domain id are
//   sampled then. Exactly one result follows per command, shown for one
//   cycle with o_valid high; the receiver cannot stall it.
// Result sequence (start edge to o_valid):
//   get, set, domain test, free: bitmap/data read, then update;
//     a slot at or above the table size is answered from idle.
//   allocate: visits bitmap words, one word per cycle.
//   free domain: walks every slot of the three non-pinned tables
//     (one slot per cycle through the bitmap and data read ports).
//   unused codes: answered from idle.
//   Busy is low again in the o_valid cycle, so the next command can be
//   taken at the edge that ends it.
// Reset: synchronous, active low. The bitmap memory is then cleared one
//   word a cycle, with busy high; hints return to zero and table sizes
//   to INITIAL_SLOTS.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_handle_table_top #(
    parameter int MAX_SLOTS     = 1024,
    parameter int INITIAL_SLOTS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [1:0]  i_handle_type,
    input  wire logic [9:0]  i_handle_slot,
    input  wire logic [63:0] i_object_ref,
    input  wire logic [15:0] i_domain_id,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [1:0]       o_out_type,
    output logic [9:0]       o_out_slot,
    output logic [63:0]      o_target_ref,
    output logic             o_in_domain
);
    localparam int OCC_AW = $clog2(MAX_SLOTS / 32) + 2;
    localparam int D_AW   = $clog2(MAX_SLOTS) + 2;

    logic              occ_we;
    logic [OCC_AW-1:0] occ_waddr, occ_raddr;
    logic [31:0]       occ_wdata, occ_rdata;
    bht_pkg::t_data_we d_we;
    logic [D_AW-1:0]   d_waddr, d_raddr;
    logic [63:0]       obj_wdata, obj_rdata;
    logic [15:0]       dom_wdata, dom_rdata;

    bht_ctrl #(
        .MAX_SLOTS     (MAX_SLOTS),
        .INITIAL_SLOTS (INITIAL_SLOTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_command     (i_command),
        .i_handle_type (i_handle_type),
        .i_handle_slot (i_handle_slot),
        .i_object_ref  (i_object_ref),
        .i_domain_id   (i_domain_id),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_type    (o_out_type),
        .o_out_slot    (o_out_slot),
        .o_target_ref  (o_target_ref),
        .o_in_domain   (o_in_domain),
        .o_occ_we      (occ_we),
        .o_occ_waddr   (occ_waddr),
        .o_occ_wdata   (occ_wdata),
        .o_occ_raddr   (occ_raddr),
        .i_occ_rdata   (occ_rdata),
        .o_d_we        (d_we),
        .o_d_waddr     (d_waddr),
        .o_obj_wdata   (obj_wdata),
        .o_dom_wdata   (dom_wdata),
        .o_d_raddr     (d_raddr),
        .i_obj_rdata   (obj_rdata),
        .i_dom_rdata   (dom_rdata)
    );

    bht_occ_mem #(
        .AW (OCC_AW)
    ) u_occ_mem (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_raddr (occ_raddr),
        .o_rdata (occ_rdata)
    );

    bht_data_mem #(
        .AW (D_AW)
    ) u_data_mem (
        .i_clk       (i_clk),
        .i_we        (d_we),
        .i_waddr     (d_waddr),
        .i_obj_wdata (obj_wdata),
        .i_dom_wdata (dom_wdata),
        .i_raddr     (d_raddr),
        .o_obj_rdata (obj_rdata),
        .o_dom_rdata (dom_rdata)
    );
endmodule
`default_nettype wire
